>>> rtl/core/esc_drive_state_controller_assert.svh
// Assertion macros for the ESC drive state controller
`ifndef ESC_DRIVE_STATE_CONTROLLER_ASSERT_SVH
`define ESC_DRIVE_STATE_CONTROLLER_ASSERT_SVH

`ifndef SYNTH
// Assert a property on an explicit clock and active-low reset.
`define ESCD_ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("esc drive state controller: assertion failed");
// Assert a property on the block clock and reset.
`define ESCD_ASSERT(name, prop) \
  `ESCD_ASSERT_CLK(name, clk_i, rst_ni, prop)
`else
`define ESCD_ASSERT_CLK(name, clk, rst_n, prop)
`define ESCD_ASSERT(name, prop)
`endif

`endif

>>> rtl/core/escd_pkg.sv
// Types and constants shared by the ESC drive state controller files
package escd_pkg;

  localparam int unsigned ModeW    = 2;
  localparam int unsigned AmountW  = 9;
  localparam int unsigned SteerW   = 8;
  localparam int unsigned AngleW   = 8;
  localparam int unsigned PulseW   = 12;
  localparam int unsigned StateW   = 2;
  localparam int unsigned SpeedW   = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  typedef enum logic [StateW-1:0] {
    DRIVE_NEUTRAL = 2'd0,
    DRIVE_FORWARD = 2'd1,
    DRIVE_BRAKING = 2'd2,
    DRIVE_REVERSE = 2'd3
  } drive_state_e;

  typedef enum logic [ModeW-1:0] {
    CMD_SET_SPEED = 2'd0,
    CMD_BRAKE     = 2'd1,
    CMD_REVERSE   = 2'd2,
    CMD_HOLD      = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STEER_RIGHT   = 3'd0,
    CFG_STEER_LEFT    = 3'd1,
    CFG_PULSE_MIN     = 3'd2,
    CFG_PULSE_NEUTRAL = 3'd3,
    CFG_PULSE_MAX     = 3'd4
  } cfg_idx_e;

  localparam logic [AngleW-1:0] SteerRightReset   = 8'd0;
  localparam logic [AngleW-1:0] SteerLeftReset    = 8'd180;
  localparam logic [PulseW-1:0] PulseMinReset     = 12'd1000;
  localparam logic [PulseW-1:0] PulseNeutralReset = 12'd1500;
  localparam logic [PulseW-1:0] PulseMaxReset     = 12'd2000;

  localparam logic signed [9:0] SpeedLimit        = 10'sd100;
  localparam logic signed [9:0] DeadBand          = 10'sd10;
  localparam logic signed [9:0] BrakeNeutralSpeed = 10'sd20;
  localparam logic signed [7:0] SteerLimit        = 8'sd100;

  // floor(2^RecipShift / 100): estimate is exact or one low
  localparam int unsigned RecipShift = 26;
  localparam int unsigned Recip100   = (1 << RecipShift) / 100;

endpackage

>>> rtl/core/escd_if.sv
// Command and result channel interfaces of the ESC drive state controller
interface escd_cmd_if;
  logic                                       valid;
  logic                                       ready;
  logic        [escd_pkg::ModeW-1:0]          mode;
  logic signed [escd_pkg::AmountW-1:0]        amount;
  logic signed [escd_pkg::SteerW-1:0]         steer_command;

  modport source (output valid, mode, amount, steer_command, input ready);
  modport sink   (input valid, mode, amount, steer_command, output ready);
endinterface

interface escd_res_if;
  logic                                       valid;
  logic                                       ready;
  logic        [escd_pkg::PulseW-1:0]         throttle_pulse_us;
  logic        [escd_pkg::AngleW-1:0]         steer_angle;
  logic        [escd_pkg::StateW-1:0]         drive_state;
  logic signed [escd_pkg::SpeedW-1:0]         speed_level;

  modport source (output valid, throttle_pulse_us, steer_angle, drive_state, speed_level,
                  input ready);
  modport sink   (input valid, throttle_pulse_us, steer_angle, drive_state, speed_level,
                  output ready);
endinterface

>>> rtl/core/esc_drive_state_controller.sv
// ESC drive state controller: speed/brake/reverse state machine and servo pulse mapping
//
//   channel  dir  handshake           payload
//   in_i     in   valid/ready         mode, amount, steer_command
//   out_o    out  valid/ready         throttle_pulse_us, steer_angle, drive_state, speed_level
//   cfg      in   cfg_we_i            cfg_index_i, cfg_wdata_i
//
// One command per cycle while the output is not stalled; each result passes through the
// four register stages: state update, products, reciprocal multiply, correction/output.
// Drive state and speed update at the input transfer, so commands chain back to back.
// A stalled output holds its stage; upstream stages keep filling until all are full.
// Reset clears state to neutral, speed to zero and loads the default register values.

`include "esc_drive_state_controller_assert.svh"

module esc_drive_state_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [escd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [escd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  escd_cmd_if.sink                       in_i,
  escd_res_if.source                     out_o
);

  // configuration registers
  logic [escd_pkg::AngleW-1:0] right_q, left_q;
  logic [escd_pkg::PulseW-1:0] pmin_q, pneu_q, pmax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_q <= escd_pkg::SteerRightReset;
      left_q  <= escd_pkg::SteerLeftReset;
      pmin_q  <= escd_pkg::PulseMinReset;
      pneu_q  <= escd_pkg::PulseNeutralReset;
      pmax_q  <= escd_pkg::PulseMaxReset;
    end else if (cfg_we_i) begin
      unique case (escd_pkg::cfg_idx_e'(cfg_index_i))
        escd_pkg::CFG_STEER_RIGHT:   right_q <= cfg_wdata_i[escd_pkg::AngleW-1:0];
        escd_pkg::CFG_STEER_LEFT:    left_q  <= cfg_wdata_i[escd_pkg::AngleW-1:0];
        escd_pkg::CFG_PULSE_MIN:     pmin_q  <= cfg_wdata_i[escd_pkg::PulseW-1:0];
        escd_pkg::CFG_PULSE_NEUTRAL: pneu_q  <= cfg_wdata_i[escd_pkg::PulseW-1:0];
        escd_pkg::CFG_PULSE_MAX:     pmax_q  <= cfg_wdata_i[escd_pkg::PulseW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic en_out, en3, en2, en1, in_fire;

  assign en_out   = ~out_valid_q | out_o.ready;
  assign en3      = ~s3_valid_q | en_out;
  assign en2      = ~s2_valid_q | en3;
  assign en1      = ~s1_valid_q | en2;
  assign in_i.ready = en1;
  assign in_fire  = in_i.valid & en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1)    s1_valid_q  <= in_fire;
      if (en2)    s2_valid_q  <= s1_valid_q;
      if (en3)    s3_valid_q  <= s2_valid_q;
      if (en_out) out_valid_q <= s3_valid_q;
    end
  end

  // drive state and speed
  escd_pkg::drive_state_e mode_q, mode_d, prev_q, prev_d;
  logic signed [escd_pkg::SpeedW-1:0] speed_q, speed_new;
  logic signed [9:0] amount_x, strength_neg, speed_cand, speed_clip;

  always_comb begin
    amount_x     = {in_i.amount[escd_pkg::AmountW-1], in_i.amount};
    strength_neg = -$signed({2'b00, in_i.amount[7:0]});
    unique case (escd_pkg::cmd_e'(in_i.mode))
      escd_pkg::CMD_SET_SPEED: speed_cand = amount_x;
      escd_pkg::CMD_BRAKE: begin
        if (mode_q == escd_pkg::DRIVE_FORWARD || mode_q == escd_pkg::DRIVE_BRAKING) begin
          speed_cand = strength_neg;
        end else begin
          speed_cand = escd_pkg::BrakeNeutralSpeed;
        end
      end
      escd_pkg::CMD_REVERSE: begin
        if (mode_q == escd_pkg::DRIVE_BRAKING) begin
          speed_cand = '0;
        end else begin
          speed_cand = strength_neg;
        end
      end
      escd_pkg::CMD_HOLD: speed_cand = {{2{speed_q[escd_pkg::SpeedW-1]}}, speed_q};
      default: speed_cand = amount_x;
    endcase

    if (speed_cand > escd_pkg::SpeedLimit) begin
      speed_clip = escd_pkg::SpeedLimit;
    end else if (speed_cand < -escd_pkg::SpeedLimit) begin
      speed_clip = -escd_pkg::SpeedLimit;
    end else begin
      speed_clip = speed_cand;
    end
    // drop small speeds inside the dead band
    if (speed_clip > -escd_pkg::DeadBand && speed_clip < escd_pkg::DeadBand) begin
      speed_clip = '0;
    end
    speed_new = speed_clip[escd_pkg::SpeedW-1:0];
  end

  // next state
  always_comb begin
    mode_d = mode_q;
    if (speed_new > 0) begin
      mode_d = escd_pkg::DRIVE_FORWARD;
    end else if (speed_new < 0) begin
      unique case (mode_q)
        escd_pkg::DRIVE_FORWARD: mode_d = escd_pkg::DRIVE_BRAKING;
        escd_pkg::DRIVE_NEUTRAL: begin
          // reverse needs a double tap: braking, neutral, then negative again
          mode_d = (prev_q == escd_pkg::DRIVE_BRAKING) ? escd_pkg::DRIVE_REVERSE
                                                        : escd_pkg::DRIVE_BRAKING;
        end
        default: mode_d = mode_q;
      endcase
    end else begin
      mode_d = escd_pkg::DRIVE_NEUTRAL;
    end
  end

  // previous state tracks only real transitions
  always_comb begin
    prev_d = (mode_d != mode_q) ? mode_q : prev_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= escd_pkg::DRIVE_NEUTRAL;
      prev_q  <= escd_pkg::DRIVE_NEUTRAL;
      speed_q <= '0;
    end else if (in_fire) begin
      mode_q  <= mode_d;
      prev_q  <= prev_d;
      speed_q <= speed_new;
    end
  end

  // stage 1: clamp steering
  logic signed [escd_pkg::SteerW-1:0] steer_clip;
  logic [8:0] steer_off9;
  logic [7:0] s1_off_q;
  escd_pkg::drive_state_e s1_state_q;
  logic signed [escd_pkg::SpeedW-1:0] s1_speed_q;

  always_comb begin
    if (in_i.steer_command > escd_pkg::SteerLimit) begin
      steer_clip = escd_pkg::SteerLimit;
    end else if (in_i.steer_command < -escd_pkg::SteerLimit) begin
      steer_clip = -escd_pkg::SteerLimit;
    end else begin
      steer_clip = in_i.steer_command;
    end
    steer_off9 = {steer_clip[escd_pkg::SteerW-1], steer_clip} + 9'd100;
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_off_q   <= steer_off9[7:0];
      s1_state_q <= mode_d;
      s1_speed_q <= speed_new;
    end
  end

  // stage 2: linear map products
  logic signed [8:0]  diff_lr;
  logic signed [17:0] steer_prod;
  logic [6:0]         pulse_span;
  logic signed [12:0] pulse_diff;
  logic signed [20:0] pulse_prod;
  logic signed [17:0] s2_steer_prod_q;
  logic signed [20:0] s2_pulse_prod_q;
  escd_pkg::drive_state_e s2_state_q;
  logic signed [escd_pkg::SpeedW-1:0] s2_speed_q;

  always_comb begin
    diff_lr    = $signed({1'b0, left_q}) - $signed({1'b0, right_q});
    steer_prod = $signed({1'b0, s1_off_q}) * diff_lr;
    if (s1_speed_q[escd_pkg::SpeedW-1]) begin
      pulse_span = 7'(s1_speed_q + 8'sd100);
      pulse_diff = $signed({1'b0, pneu_q}) - $signed({1'b0, pmin_q});
    end else begin
      pulse_span = s1_speed_q[6:0];
      pulse_diff = $signed({1'b0, pmax_q}) - $signed({1'b0, pneu_q});
    end
    pulse_prod = $signed({1'b0, pulse_span}) * pulse_diff;
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_steer_prod_q <= steer_prod;
      s2_pulse_prod_q <= pulse_prod;
      s2_state_q      <= s1_state_q;
      s2_speed_q      <= s1_speed_q;
    end
  end

  // stage 3: magnitudes and reciprocal estimates (steering x/200 as (x>>1)/100, pulse x/100)
  logic [17:0] steer_abs;
  logic [20:0] pulse_abs;
  logic [14:0] steer_mag;
  logic [18:0] pulse_mag;
  logic [34:0] steer_recip;
  logic [38:0] pulse_recip;
  logic [7:0]  s3_steer_est_q;
  logic [14:0] s3_steer_mag_q;
  logic        s3_steer_neg_q;
  logic [11:0] s3_pulse_est_q;
  logic [18:0] s3_pulse_mag_q;
  logic        s3_pulse_neg_q;
  escd_pkg::drive_state_e s3_state_q;
  logic signed [escd_pkg::SpeedW-1:0] s3_speed_q;

  always_comb begin
    steer_abs   = s2_steer_prod_q[17] ? 18'(-s2_steer_prod_q) : 18'(s2_steer_prod_q);
    pulse_abs   = s2_pulse_prod_q[20] ? 21'(-s2_pulse_prod_q) : 21'(s2_pulse_prod_q);
    steer_mag   = steer_abs[15:1];
    pulse_mag   = pulse_abs[18:0];
    steer_recip = 35'(steer_mag) * 35'(escd_pkg::Recip100);
    pulse_recip = 39'(pulse_mag) * 39'(escd_pkg::Recip100);
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_steer_est_q <= steer_recip[escd_pkg::RecipShift+7:escd_pkg::RecipShift];
      s3_steer_mag_q <= steer_mag;
      s3_steer_neg_q <= s2_steer_prod_q[17];
      s3_pulse_est_q <= pulse_recip[escd_pkg::RecipShift+11:escd_pkg::RecipShift];
      s3_pulse_mag_q <= pulse_mag;
      s3_pulse_neg_q <= s2_pulse_prod_q[20];
      s3_state_q     <= s2_state_q;
      s3_speed_q     <= s2_speed_q;
    end
  end

  // output stage: correct the estimate, restore sign, add the base
  logic [14:0] steer_est_x, steer_rem;
  logic [7:0]  steer_quo;
  logic [18:0] pulse_est_x, pulse_rem;
  logic [11:0] pulse_quo, pulse_base;
  logic [escd_pkg::AngleW-1:0] angle_d;
  logic [escd_pkg::PulseW-1:0] pulse_d;
  logic [escd_pkg::PulseW-1:0] out_pulse_q;
  logic [escd_pkg::AngleW-1:0] out_angle_q;
  escd_pkg::drive_state_e out_state_q;
  logic signed [escd_pkg::SpeedW-1:0] out_speed_q;

  always_comb begin
    steer_est_x = 15'(s3_steer_est_q) * 15'd100;
    steer_rem   = s3_steer_mag_q - steer_est_x;
    steer_quo   = s3_steer_est_q + 8'(steer_rem >= 15'd100);
    angle_d     = s3_steer_neg_q ? right_q - steer_quo : right_q + steer_quo;

    pulse_est_x = 19'(s3_pulse_est_q) * 19'd100;
    pulse_rem   = s3_pulse_mag_q - pulse_est_x;
    pulse_quo   = s3_pulse_est_q + 12'(pulse_rem >= 19'd100);
    pulse_base  = s3_speed_q[escd_pkg::SpeedW-1] ? pmin_q : pneu_q;
    pulse_d     = s3_pulse_neg_q ? pulse_base - pulse_quo : pulse_base + pulse_quo;
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      out_pulse_q <= pulse_d;
      out_angle_q <= angle_d;
      out_state_q <= s3_state_q;
      out_speed_q <= s3_speed_q;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.throttle_pulse_us = out_pulse_q;
  assign out_o.steer_angle       = out_angle_q;
  assign out_o.drive_state       = out_state_q;
  assign out_o.speed_level       = out_speed_q;

  // assertions
  `ESCD_ASSERT(a_speed_range, speed_q >= -8'sd100 && speed_q <= 8'sd100)
  `ESCD_ASSERT(a_speed_dead_band, speed_q == 8'sd0 || speed_q >= 8'sd10 || speed_q <= -8'sd10)
  `ESCD_ASSERT(a_state_speed_sign,
               ((speed_q > 0) == (mode_q == escd_pkg::DRIVE_FORWARD)) &&
               ((speed_q == 0) == (mode_q == escd_pkg::DRIVE_NEUTRAL)))
  `ESCD_ASSERT(a_reverse_double_tap,
               (mode_q == escd_pkg::DRIVE_REVERSE && $past(mode_q) != escd_pkg::DRIVE_REVERSE)
               |-> ($past(mode_q) == escd_pkg::DRIVE_NEUTRAL &&
                    $past(prev_q) == escd_pkg::DRIVE_BRAKING))
  `ESCD_ASSERT_CLK(a_prev_tracks_change, clk_i, rst_ni,
                   (mode_q != $past(mode_q)) |-> (prev_q == $past(mode_q)))

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the ESC drive state controller: directed table, then random phases
module testbench;
  import escd_pkg::*;

  localparam int NumPhases      = 10;
  localparam int PhaseItems     = 130;
  localparam int PausePhase     = 5;
  localparam int RxHoldCycles   = 80;
  localparam int SettleCycles   = 8;
  localparam int SettleLimit    = 20000;
  localparam int MaxPrinted     = 50;
  localparam int CfgFirstUnused = 5;

  typedef struct packed {
    logic [PulseW-1:0]        pulse;
    logic [AngleW-1:0]        angle;
    drive_state_e             state;
    logic signed [SpeedW-1:0] speed;
  } esc_result_t;

  typedef struct packed {
    cmd_e                      mode;
    logic signed [AmountW-1:0] amount;
    logic signed [SteerW-1:0]  steer;
    logic                      known;
    esc_result_t               want;
  } period_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  escd_cmd_if cmd_if ();
  escd_res_if res_if ();

  esc_drive_state_controller dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (cmd_if),
    .out_o       (res_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state and its copy of the registers
  drive_state_e      drv_state, drv_prev_state;
  int                drv_speed;
  logic [AngleW-1:0] reg_right_deg, reg_left_deg;
  logic [PulseW-1:0] reg_min_us, reg_neutral_us, reg_max_us;

  esc_result_t pending_results [$];
  period_row_t period_tab [25];
  int error_count = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold_req = 0;
  int rx_hold_ack = 0;
  int rx_hold_left = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < MaxPrinted)
      $display("MISMATCH %s: got %0d, want %0d", what, got, want);
    error_count++;
  endtask

  function automatic int clamp_pct(input int v);
    if (v < -100) return -100;
    if (v > 100) return 100;
    return v;
  endfunction

  // Clamp to +/-100, then zero anything strictly inside the dead band
  function automatic int shape_speed(input int v);
    int c;
    c = clamp_pct(v);
    if (c > -10 && c < 10) return 0;
    return c;
  endfunction

  function automatic int brake_speed(input int strength);
    if (drv_state == DRIVE_BRAKING || drv_state == DRIVE_FORWARD) return shape_speed(-strength);
    return shape_speed(20);
  endfunction

  function automatic esc_result_t predict_period(input cmd_e mode,
                                                 input logic signed [AmountW-1:0] amount,
                                                 input logic signed [SteerW-1:0] steer_cmd);
    esc_result_t r;
    int steer, strength, steer_deg, pulse;
    int rgt, lft, mn, nu, mx;
    drive_state_e next;
    steer    = clamp_pct(int'(steer_cmd));
    strength = int'(amount[7:0]);
    rgt = int'(reg_right_deg);
    lft = int'(reg_left_deg);
    mn  = int'(reg_min_us);
    nu  = int'(reg_neutral_us);
    mx  = int'(reg_max_us);
    steer_deg = (steer + 100) * (lft - rgt) / 200 + rgt;
    case (mode)
      CMD_SET_SPEED: drv_speed = shape_speed(int'(amount));
      CMD_BRAKE:     drv_speed = brake_speed(strength);
      CMD_REVERSE: begin
        if (drv_state == DRIVE_FORWARD) drv_speed = brake_speed(strength);
        else if (drv_state == DRIVE_BRAKING) drv_speed = 0;
        else drv_speed = shape_speed(-strength);
      end
      default: ;
    endcase
    next = drv_state;
    if (drv_speed > 0) begin
      next = DRIVE_FORWARD;
    end else if (drv_speed < 0) begin
      if (drv_state == DRIVE_FORWARD) next = DRIVE_BRAKING;
      else if (drv_state == DRIVE_NEUTRAL)
        next = (drv_prev_state == DRIVE_BRAKING) ? DRIVE_REVERSE : DRIVE_BRAKING;
    end else begin
      next = DRIVE_NEUTRAL;
    end
    // previous state moves only on an actual change
    if (next != drv_state) begin
      drv_prev_state = drv_state;
      drv_state = next;
    end
    if (drv_speed >= 0) pulse = drv_speed * (mx - nu) / 100 + nu;
    else pulse = (drv_speed + 100) * (nu - mn) / 100 + mn;
    r.pulse = pulse[PulseW-1:0];
    r.angle = steer_deg[AngleW-1:0];
    r.state = drv_state;
    r.speed = drv_speed[SpeedW-1:0];
    return r;
  endfunction

  task automatic send_period(input cmd_e mode, input logic signed [AmountW-1:0] amount,
                             input logic signed [SteerW-1:0] steer_cmd, input logic known,
                             input esc_result_t typed);
    esc_result_t want;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid         <= 1'b1;
    cmd_if.mode          <= mode;
    cmd_if.amount        <= amount;
    cmd_if.steer_command <= steer_cmd;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    want = predict_period(mode, amount, steer_cmd);
    if (known) want = typed;
    pending_results.push_back(want);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_STEER_RIGHT:   reg_right_deg  = data[AngleW-1:0];
      CFG_STEER_LEFT:    reg_left_deg   = data[AngleW-1:0];
      CFG_PULSE_MIN:     reg_min_us     = data[PulseW-1:0];
      CFG_PULSE_NEUTRAL: reg_neutral_us = data[PulseW-1:0];
      CFG_PULSE_MAX:     reg_max_us     = data[PulseW-1:0];
      default: ;
    endcase
  endtask

  task automatic program_setting(input int which);
    logic [CfgDataW-1:0] right, left, pmin, pneu, pmax;
    case (which)
      0: begin
        right = 12'(SteerRightReset);
        left  = 12'(SteerLeftReset);
        pmin  = PulseMinReset;
        pneu  = PulseNeutralReset;
        pmax  = PulseMaxReset;
      end
      1: begin
        right = '0; left = '0; pmin = '0; pneu = '0; pmax = '0;
      end
      2: begin
        right = '1; left = '1; pmin = '1; pneu = '1; pmax = '1;
      end
      3: begin
        // swapped endpoints: both maps run downhill
        right = 12'd180; left = 12'd0; pmin = 12'd2000; pneu = 12'd1500; pmax = 12'd1000;
      end
      4: begin
        right = 12'd0; left = 12'd180; pmin = 12'd0; pneu = 12'd1500; pmax = 12'd3000;
      end
      5: begin
        right = 12'($urandom); left = 12'($urandom);
        pmin = 12'($urandom); pneu = 12'($urandom); pmax = 12'($urandom);
      end
      default: begin
        right = 12'($urandom_range(180)); left = 12'($urandom_range(180));
        pmin = 12'($urandom_range(3000)); pneu = 12'($urandom_range(3000));
        pmax = 12'($urandom_range(3000));
      end
    endcase
    write_reg(CFG_STEER_RIGHT, right);
    write_reg(CFG_STEER_LEFT, left);
    write_reg(CFG_PULSE_MIN, pmin);
    write_reg(CFG_PULSE_NEUTRAL, pneu);
    write_reg(CFG_PULSE_MAX, pmax);
    // no register behind these indexes: the write must be dropped
    write_reg(3'($urandom_range(7, CfgFirstUnused)), 12'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, drain every pending result, then let the pipeline go quiet
  task automatic settle();
    int waited;
    cmd_if.valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < SettleLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch("results never arrived", pending_results.size(), 0);
      pending_results.delete();
    end
  endtask

  task automatic check_result();
    esc_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with none pending", int'(res_if.throttle_pulse_us), 0);
      return;
    end
    want = pending_results.pop_front();
    if (res_if.throttle_pulse_us !== want.pulse)
      report_mismatch("throttle_pulse_us", int'(res_if.throttle_pulse_us), int'(want.pulse));
    if (res_if.steer_angle !== want.angle)
      report_mismatch("steer_angle", int'(res_if.steer_angle), int'(want.angle));
    if (res_if.drive_state !== want.state)
      report_mismatch("drive_state", int'(res_if.drive_state), int'(want.state));
    if (res_if.speed_level !== want.speed)
      report_mismatch("speed_level", int'(res_if.speed_level), int'(want.speed));
  endtask

  // Result side: check each transfer, then pick ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) check_result();
    if (rx_hold_req != rx_hold_ack) begin
      rx_hold_ack  = rx_hold_req;
      rx_hold_left = RxHoldCycles;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= !(rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int i, phase, sent, v;
    logic paused;
    cmd_e mode;
    logic signed [AmountW-1:0] amount;
    logic signed [SteerW-1:0] steer_cmd;

    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_wdata            = '0;
    cmd_if.valid         = 1'b0;
    cmd_if.mode          = CMD_SET_SPEED;
    cmd_if.amount        = '0;
    cmd_if.steer_command = '0;
    reg_right_deg  = SteerRightReset;
    reg_left_deg   = SteerLeftReset;
    reg_min_us     = PulseMinReset;
    reg_neutral_us = PulseNeutralReset;
    reg_max_us     = PulseMaxReset;
    drv_state      = DRIVE_NEUTRAL;
    drv_prev_state = DRIVE_NEUTRAL;
    drv_speed      = 0;
    paused         = 1'b0;

    period_tab = '{
      '{CMD_SET_SPEED,  9'sd0,    8'sd0,   1'b1, '{12'd1500,  8'd90, DRIVE_NEUTRAL,  8'sd0}},
      '{CMD_SET_SPEED,  9'sd255,  8'sd127, 1'b1, '{12'd2000, 8'd180, DRIVE_FORWARD,  8'sd100}},
      '{CMD_SET_SPEED,  9'sh100,  8'sh80,  1'b1, '{12'd1000,   8'd0, DRIVE_BRAKING, -8'sd100}},
      '{CMD_SET_SPEED,  9'sd0,    8'sd0,   1'b1, '{12'd1500,  8'd90, DRIVE_NEUTRAL,  8'sd0}},
      // double tap: braking, neutral, then negative goes to reverse
      '{CMD_SET_SPEED, -9'sd50,   8'sd0,   1'b1, '{12'd1250,  8'd90, DRIVE_REVERSE, -8'sd50}},
      '{CMD_SET_SPEED, -9'sd200,  8'sd0,   1'b1, '{12'd1000,  8'd90, DRIVE_REVERSE, -8'sd100}},
      '{CMD_BRAKE,      9'sd30,   8'sd0,   1'b1, '{12'd1600,  8'd90, DRIVE_FORWARD,  8'sd20}},
      '{CMD_BRAKE,      9'sd40,   8'sd0,   1'b1, '{12'd1300,  8'd90, DRIVE_BRAKING, -8'sd40}},
      '{CMD_BRAKE,      9'sd9,    8'sd0,   1'b1, '{12'd1500,  8'd90, DRIVE_NEUTRAL,  8'sd0}},
      '{CMD_BRAKE,      9'sd0,    8'sd0,   1'b1, '{12'd1600,  8'd90, DRIVE_FORWARD,  8'sd20}},
      '{CMD_REVERSE,    9'sd60,   8'sd0,   1'b1, '{12'd1200,  8'd90, DRIVE_BRAKING, -8'sd60}},
      '{CMD_REVERSE,    9'sd77,   8'sd0,   1'b1, '{12'd1500,  8'd90, DRIVE_NEUTRAL,  8'sd0}},
      '{CMD_REVERSE,    9'sd70,   8'sd0,   1'b1, '{12'd1150,  8'd90, DRIVE_REVERSE, -8'sd70}},
      '{CMD_HOLD,       9'sd255,  8'sd50,  1'b1, '{12'd1150, 8'd135, DRIVE_REVERSE, -8'sd70}},
      // negative strength reads as its low byte and saturates
      '{CMD_REVERSE,   -9'sd5,   -8'sd50,  1'b1, '{12'd1000,  8'd45, DRIVE_REVERSE, -8'sd100}},
      '{CMD_SET_SPEED,  9'sd10,   8'sd0,   1'b1, '{12'd1550,  8'd90, DRIVE_FORWARD,  8'sd10}},
      '{CMD_SET_SPEED, -9'sd10,   8'sd0,   1'b1, '{12'd1450,  8'd90, DRIVE_BRAKING, -8'sd10}},
      '{CMD_SET_SPEED, -9'sd9,    8'sd0,   1'b1, '{12'd1500,  8'd90, DRIVE_NEUTRAL,  8'sd0}},
      '{CMD_SET_SPEED,  9'sd9,   -8'sd1,   1'b0, '0},
      '{CMD_SET_SPEED,  9'sd50,   8'sd1,   1'b0, '0},
      '{CMD_SET_SPEED,  9'sd0,    8'sd0,   1'b1, '{12'd1500,  8'd90, DRIVE_NEUTRAL,  8'sd0}},
      // single tap from neutral only brakes
      '{CMD_SET_SPEED, -9'sd30,   8'sd0,   1'b1, '{12'd1350,  8'd90, DRIVE_BRAKING, -8'sd30}},
      '{CMD_BRAKE,      9'sd255,  8'sd0,   1'b1, '{12'd1000,  8'd90, DRIVE_BRAKING, -8'sd100}},
      '{CMD_HOLD,      -9'sd1,    8'sd100, 1'b1, '{12'd1000, 8'd180, DRIVE_BRAKING, -8'sd100}},
      '{CMD_SET_SPEED,  9'sd255, -8'sd101, 1'b1, '{12'd2000,   8'd0, DRIVE_FORWARD,  8'sd100}}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < 25; i++)
      send_period(period_tab[i].mode, period_tab[i].amount, period_tab[i].steer,
                  period_tab[i].known, period_tab[i].want);

    for (phase = 0; phase < NumPhases; phase++) begin
      settle();
      program_setting(phase);
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct = 51; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct <= 51; end
        default: begin tx_idle_pct = 30; rx_stall_pct <= 30; end
      endcase
      // hold the result side off while commands keep coming, to fill the pipeline
      if (phase == 0) rx_hold_req <= rx_hold_req + 1;
      sent = 0;
      while (sent < PhaseItems) begin
        if (phase == PausePhase && !paused && sent >= PhaseItems / 2) begin
          settle();
          paused = 1'b1;
        end
        if ($urandom_range(9) == 0) begin
          // forward, brake, back to neutral, then reverse on the second tap
          send_period(CMD_SET_SPEED, 9'($urandom_range(255, 10)), 8'($urandom), 1'b0, '0);
          send_period(CMD_SET_SPEED, 9'(-int'($urandom_range(255, 10))), 8'($urandom),
                      1'b0, '0);
          case ($urandom_range(2))
            0: send_period(CMD_SET_SPEED, 9'(int'($urandom_range(18)) - 9), 8'($urandom),
                           1'b0, '0);
            1: send_period(CMD_REVERSE, 9'($urandom), 8'($urandom), 1'b0, '0);
            default: send_period(CMD_BRAKE, 9'($urandom_range(9)), 8'($urandom), 1'b0, '0);
          endcase
          if ($urandom_range(1) == 0)
            send_period(CMD_SET_SPEED, 9'(-int'($urandom_range(255, 10))), 8'($urandom),
                        1'b0, '0);
          else
            send_period(CMD_REVERSE, {1'($urandom), 8'($urandom_range(255, 10))},
                        8'($urandom), 1'b0, '0);
          sent += 4;
        end else begin
          mode = cmd_e'($urandom_range(3));
          case ($urandom_range(9))
            0, 1, 2: begin
              v = int'($urandom_range(24)) - 12;
              amount = 9'(v);
            end
            3: begin
              case ($urandom_range(5))
                0: v = 255;
                1: v = -256;
                2: v = 100;
                3: v = -100;
                4: v = 101;
                default: v = -101;
              endcase
              amount = 9'(v);
            end
            default: amount = 9'($urandom);
          endcase
          if ($urandom_range(1) == 0) steer_cmd = 8'($urandom);
          else steer_cmd = 8'(int'($urandom_range(200)) - 100);
          send_period(mode, amount, steer_cmd, 1'b0, '0);
          sent++;
        end
      end
    end

    settle();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/escd_pkg.sv
rtl/core/escd_if.sv
rtl/core/esc_drive_state_controller.sv
tb/testbench.sv
